>>> rtl/ffca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg: shared types and constants of the free-segment allocator
// Command codes, status codes, register indexes and the controller interface.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int unsigned MaxSegments = 16;
  localparam int unsigned SegIdxW     = $clog2(MaxSegments);
  localparam int unsigned SegCntW     = $clog2(MaxSegments + 1);
  localparam int unsigned GranuleLog2 = 4;
  localparam logic [32:0] GranuleBytes = 33'd16;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_FIT    = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic REG_MEM_START = 1'b0;
  localparam logic REG_MEM_END   = 1'b1;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;       // capture the incoming transfer
    logic do_init;    // build the single initial segment
    logic scan_step;  // compare entry at the scan index, advance
    logic setup;      // fix the shift plan once the scan has its answer
    logic shift_step; // move one entry for insert or remove
    logic finish;     // apply the final update and form the result
  } ffca_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic scan_done;  // search has its answer
    logic shift_done; // no more entries to move
  } ffca_sts_t;

  // Round a 32-bit value up to the granule; 33 bits keep the carry.
  function automatic logic [32:0] round_up(input logic [32:0] v);
    logic [32:0] s;
    s = v + GranuleBytes - 33'd1;
    return {s[32:GranuleLog2], {GranuleLog2{1'b0}}};
  endfunction

endpackage

>>> rtl/first_fit_coalescing_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_top: first-fit free-list allocator
// Keeps an address-ordered free-segment table with merge on free.
// ----------------------------------------------------------------------------
// A command passes capture, table scan, shift-plan setup, entry shifting, finish and
// result; the scan steps once per scanned entry and the shift once per moved entry.
// One command in flight; the next input transfer can come in the cycle after the
// output transfer.
// Reset clears the segment count, capacity and controller; table entries
// stay undefined until an init command writes them.
module first_fit_coalescing_allocator_top
  import ffca_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [23:0] request_size_i,
  input  logic [31:0] freed_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] block_address_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  ffca_cmd_t cmd;
  ffca_sts_t sts;
  ffca_cmd_t cmd_x;
  logic      cfg_we;

  // Configuration is always taken; indexes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && (cfg_index_i[1] == 1'b0);

  ffca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The init build happens in the first step after capture.
  always_comb begin
    cmd_x = cmd;
    cmd_x.do_init = cmd.scan_step && 1'b0;
  end

  logic init_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b0;
    end else begin
      init_q <= cmd.load && (command_i == CMD_INIT);
    end
  end

  ffca_cmd_t cmd_dp;
  always_comb begin
    cmd_dp = cmd_x;
    cmd_dp.do_init = init_q;
  end

  ffca_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_dp),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_index_i[0]),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .request_size_i  (request_size_i),
    .freed_address_i (freed_address_i),
    .block_address_o (block_address_o),
    .status_o        (status_o)
  );

endmodule

>>> rtl/ffca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_ctrl: allocator sequencer
// Walks each command through capture, table scan, entry shifting and result.
// ----------------------------------------------------------------------------
module ffca_ctrl
  import ffca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output ffca_cmd_t cmd_o,
  input  ffca_sts_t sts_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.setup = 1'b1;
          state_d = S_SHIFT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SCAN) else $error("load did not start scan");
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o) else $error("finish not followed by result");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("overlapping datapath commands");
`endif

endmodule

>>> rtl/ffca_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_dp: segment table and arithmetic
// Holds the free-segment table, scans it one entry per cycle and shifts
// entries one per cycle for insertion and removal.
// ----------------------------------------------------------------------------
module ffca_dp
  import ffca_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ffca_cmd_t   cmd_i,
  output ffca_sts_t   sts_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  command_i,
  input  logic [23:0] request_size_i,
  input  logic [31:0] freed_address_i,
  output logic [31:0] block_address_o,
  output logic [1:0]  status_o
);

  logic [31:0] seg_start_q [MaxSegments];
  logic [31:0] seg_len_q   [MaxSegments];
  logic [SegCntW-1:0] count_q;
  logic [31:0] capacity_q;
  logic [31:0] mem_start_q, mem_end_q;

  logic [1:0]  cmd_q;
  logic [32:0] size_q;     // rounded size, up to 2^24
  logic [31:0] faddr_q;
  logic [SegCntW-1:0] pos_q;   // scan position
  logic [SegCntW-1:0] sh_q;    // shift cursor
  logic        found_q;        // scan ended with a hit; set by alloc only
  logic [31:0] addr_q;
  logic [1:0]  st_q;
  // Shift plan fixed when the scan ends, since shifting rewrites the entries
  // the plan was derived from.
  logic        rm_q, ins_q;
  logic [31:0] mlen_q;         // merged length of a two-sided merge

  // Scan entry: its start and length, and whether the index is inside the table.
  logic [SegIdxW-1:0] pidx;
  logic [31:0] cur_s, cur_l;
  logic        pos_in;
  assign pidx   = pos_q[SegIdxW-1:0];
  assign pos_in = pos_q < count_q;
  assign cur_s  = seg_start_q[pidx];
  assign cur_l  = seg_len_q[pidx];

  // Neighbours for free, valid when the free scan has stopped.
  logic [SegIdxW-1:0] lidx;
  logic [31:0] l_s, l_l;
  logic [32:0] l_end, l_end2, f_end;
  logic        has_l, adj_l, adj_r, adj_both;
  assign lidx  = pidx - 1'b1;
  assign l_s   = seg_start_q[lidx];
  assign l_l   = seg_len_q[lidx];
  assign has_l = pos_q != '0;
  assign l_end = {1'b0, l_s} + {1'b0, l_l};
  assign adj_l = has_l && (l_end == {1'b0, faddr_q});
  assign l_end2 = {1'b0, l_s} + {1'b0, l_l + size_q[31:0]};
  assign adj_both = adj_l && pos_in && (l_end2 == {1'b0, cur_s});
  assign f_end = {1'b0, faddr_q} + size_q;
  assign adj_r = !adj_l && pos_in && (f_end == {1'b0, cur_s});

  // Alloc fit tests on the entry at the scan index.
  logic fit, exact;
  assign fit   = {1'b0, cur_l} >= size_q;
  assign exact = {1'b0, cur_l} == size_q;

  // Which kind of shift the command needs, taken into the plan at setup.
  logic need_remove, need_insert, full;
  assign full        = count_q >= SegCntW'(MaxSegments);
  assign need_remove = (cmd_q == CMD_ALLOC && found_q && exact) ||
                       (cmd_q == CMD_FREE && adj_both);
  assign need_insert = cmd_q == CMD_FREE && !adj_l && !adj_r && !full;

  always_comb begin
    sts_o.scan_done = 1'b1;
    case (cmd_q)
      CMD_ALLOC: sts_o.scan_done = found_q || !pos_in || (st_q == ST_TOO_LARGE);
      CMD_FREE:  sts_o.scan_done = !pos_in || !(faddr_q > cur_s);
      default:   sts_o.scan_done = 1'b1;
    endcase
    // Remove walks the cursor up from the hole; insert walks it down.
    if (rm_q) begin
      sts_o.shift_done = !((sh_q + 1'b1) < count_q);
    end else if (ins_q) begin
      sts_o.shift_done = !(sh_q > pos_q);
    end else begin
      sts_o.shift_done = 1'b1;
    end
  end

  logic [32:0] rs, re, rsz;
  assign rs  = round_up({1'b0, mem_start_q});
  assign re  = round_up({1'b0, mem_end_q});
  assign rsz = (request_size_i == '0) ? GranuleBytes : round_up({9'd0, request_size_i});

  logic [32:0] hdr_end;
  assign hdr_end = rs + GranuleBytes;

  logic [SegIdxW-1:0] shi, shi_n, shi_p;
  assign shi   = sh_q[SegIdxW-1:0];
  assign shi_n = shi + 1'b1;
  assign shi_p = shi - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_init && re > hdr_end) begin
      seg_start_q[0] <= hdr_end[31:0];
      seg_len_q[0]   <= 32'(re - hdr_end);
    end
    if (cmd_i.shift_step) begin
      if (rm_q) begin
        seg_start_q[shi] <= seg_start_q[shi_n];
        seg_len_q[shi]   <= seg_len_q[shi_n];
      end else begin
        seg_start_q[shi] <= seg_start_q[shi_p];
        seg_len_q[shi]   <= seg_len_q[shi_p];
      end
    end
    if (cmd_i.finish) begin
      if (cmd_q == CMD_ALLOC && found_q && !rm_q) begin
        seg_start_q[pidx] <= cur_s + size_q[31:0];
        seg_len_q[pidx]   <= cur_l - size_q[31:0];
      end else if (cmd_q == CMD_FREE) begin
        if (rm_q) begin
          seg_len_q[lidx] <= mlen_q;
        end else if (adj_l) begin
          seg_len_q[lidx] <= l_l + size_q[31:0];
        end else if (adj_r) begin
          seg_start_q[pidx] <= faddr_q;
          seg_len_q[pidx]   <= cur_l + size_q[31:0];
        end else if (!full) begin
          seg_start_q[pidx] <= faddr_q;
          seg_len_q[pidx]   <= size_q[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= command_i;
      size_q  <= rsz;
      faddr_q <= freed_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      capacity_q  <= '0;
      mem_start_q <= 32'd0;
      mem_end_q   <= 32'd65536;
      pos_q       <= '0;
      sh_q        <= '0;
      found_q     <= 1'b0;
      addr_q      <= '0;
      st_q        <= ST_OK;
      rm_q        <= 1'b0;
      ins_q       <= 1'b0;
      mlen_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MEM_START) mem_start_q <= cfg_data_i;
        else                            mem_end_q   <= cfg_data_i;
      end
      if (cmd_i.load) begin
        pos_q   <= '0;
        found_q <= 1'b0;
        addr_q  <= '0;
        st_q    <= ST_OK;
        if (command_i == CMD_ALLOC && rsz > {1'b0, capacity_q}) begin
          st_q <= ST_TOO_LARGE;
        end
        if (command_i == CMD_INIT) begin
          count_q    <= '0;
          capacity_q <= '0;
        end
      end
      if (cmd_i.do_init && re > hdr_end) begin
        count_q    <= SegCntW'(1);
        capacity_q <= 32'(re - hdr_end);
      end
      if (cmd_i.scan_step) begin
        if (cmd_q == CMD_ALLOC && fit) begin
          found_q <= 1'b1;
          addr_q  <= cur_s;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      // Cursor and shift plan are fixed as the scan finishes.
      if (cmd_i.setup) begin
        sh_q   <= need_remove ? pos_q : count_q;
        rm_q   <= need_remove;
        ins_q  <= need_insert;
        mlen_q <= l_l + size_q[31:0] + cur_l;
      end
      if (cmd_i.shift_step) begin
        sh_q <= rm_q ? sh_q + 1'b1 : sh_q - 1'b1;
      end
      if (cmd_i.finish) begin
        if (rm_q) count_q <= count_q - 1'b1;
        if (ins_q) count_q <= count_q + 1'b1;
        if (cmd_q == CMD_ALLOC && st_q == ST_OK && !found_q) st_q <= ST_NO_FIT;
        if (cmd_q == CMD_FREE && !adj_l && !adj_r && full) st_q <= ST_FULL;
      end
    end
  end

  assign block_address_o = addr_q;
  assign status_o        = st_q;

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SegCntW'(MaxSegments)) else $error("segment count overflow");
  a_addr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_OK) |-> addr_q == '0) else $error("address on failed status");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> pos_in) else $error("scan beyond table");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the first-fit coalescing allocator
// Drives init, allocate and free commands over the valid/ready input channel,
// predicts each result with a behavioral free-segment table and compares the
// block's results in order. Configuration is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
  import ffca_pkg::*;

  // One pending command for the driver.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] size;
    logic [31:0] addr;
  } alloc_req_t;

  // One predicted result.
  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
  } alloc_rsp_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_NOP;
  logic [23:0] request_size = '0;
  logic [31:0] freed_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] block_address;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Queue of commands not yet offered, and results still owed by the block.
  alloc_req_t pending_reqs[$];
  alloc_rsp_t owed_rsps[$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off = 0;    // long receiver stall requested by the stimulus
  logic        stim_done = 1'b0;

  // Behavioral copy of the block's state and configuration.
  logic [31:0] seg_base[MaxSegments];
  logic [31:0] seg_len[MaxSegments];
  int unsigned seg_cnt;
  logic [31:0] capacity;
  logic [31:0] mem_start_q;
  logic [31:0] mem_end_q;

  // Allocated blocks that can be handed back later: base and requested size.
  logic [31:0] live_base[$];
  logic [23:0] live_size[$];

  first_fit_coalescing_allocator_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .request_size_i (request_size),
    .freed_address_i(freed_address),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .block_address_o(block_address),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk = ~clk;

  // Size in bytes after rounding up to the granule; zero means one granule.
  function automatic logic [32:0] granted_bytes(input logic [23:0] raw);
    logic [32:0] v;
    v = {9'd0, raw};
    if (v == 33'd0) return 33'd16;
    return ((v + 33'd15) >> 4) << 4;
  endfunction

  function automatic logic [32:0] rounded(input logic [31:0] v);
    return (({1'b0, v} + 33'd15) >> 4) << 4;
  endfunction

  task automatic drop_segment(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < seg_cnt; i++) begin
      seg_base[i] = seg_base[i + 1];
      seg_len[i]  = seg_len[i + 1];
    end
    seg_cnt--;
  endtask

  // Computes what the allocator answers to one command and updates the table.
  task automatic predict_alloc(input alloc_req_t req, output alloc_rsp_t rsp);
    logic [32:0] s, e, sz;
    logic [31:0] sz32;
    int unsigned pos;
    bit          found;
    rsp = '{block_address: 32'd0, status: ST_OK};
    case (req.cmd)
      CMD_INIT: begin
        s = rounded(mem_start_q);
        e = rounded(mem_end_q);
        seg_cnt = 0;
        capacity = '0;
        if ({1'b0, e} > {1'b0, s} + 34'd16) begin
          capacity = 32'(e - s - 33'd16);
          seg_base[0] = 32'(s + 33'd16);
          seg_len[0] = capacity;
          seg_cnt = 1;
        end
      end
      CMD_ALLOC: begin
        sz = granted_bytes(req.size);
        sz32 = sz[31:0];
        found = 1'b0;
        if (sz > {1'b0, capacity}) begin
          rsp.status = ST_TOO_LARGE;
        end else begin
          for (int unsigned i = 0; i < seg_cnt && !found; i++) begin
            if ({1'b0, seg_len[i]} >= sz) begin
              found = 1'b1;
              rsp.block_address = seg_base[i];
              if ({1'b0, seg_len[i]} == sz) begin
                drop_segment(i);
              end else begin
                seg_base[i] = seg_base[i] + sz32;
                seg_len[i]  = seg_len[i] - sz32;
              end
            end
          end
          if (!found) rsp.status = ST_NO_FIT;
        end
      end
      CMD_FREE: begin
        sz = granted_bytes(req.size);
        sz32 = sz[31:0];
        pos = 0;
        while (pos < seg_cnt && req.addr > seg_base[pos]) pos++;
        if (pos > 0 && {1'b0, seg_base[pos-1]} + {1'b0, seg_len[pos-1]} == {1'b0, req.addr})
        begin
          // Merge with the left neighbor, and then possibly the right one too.
          seg_len[pos-1] = seg_len[pos-1] + sz32;
          if (pos < seg_cnt &&
              {1'b0, seg_base[pos-1]} + {1'b0, seg_len[pos-1]} == {1'b0, seg_base[pos]})
          begin
            seg_len[pos-1] = seg_len[pos-1] + seg_len[pos];
            drop_segment(pos);
          end
        end else if (pos < seg_cnt &&
                     {1'b0, req.addr} + {1'b0, sz32} == {1'b0, seg_base[pos]}) begin
          seg_base[pos] = req.addr;
          seg_len[pos]  = seg_len[pos] + sz32;
        end else if (seg_cnt >= MaxSegments) begin
          rsp.status = ST_FULL;
        end else begin
          for (int unsigned i = seg_cnt; i > pos; i--) begin
            seg_base[i] = seg_base[i-1];
            seg_len[i]  = seg_len[i-1];
          end
          seg_base[pos] = req.addr;
          seg_len[pos]  = sz32;
          seg_cnt++;
        end
      end
      default: ;
    endcase
  endtask

  // Input transfer seen at the last rising edge.
  logic in_ready_seen = 1'b0;

  // Driver: offers queued commands at the falling edge with random gaps.
  int unsigned drive_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_seen) begin
        if (pending_reqs.size() > 0 && drive_gap == 0) begin
          command       <= pending_reqs[0].cmd;
          request_size  <= pending_reqs[0].size;
          freed_address <= pending_reqs[0].addr;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
        drive_gap = ($urandom_range(0, 9) == 0) ?
                    (($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
                    : 0;
      end else if (!in_valid) begin
        if (drive_gap > 0) begin
          drive_gap--;
        end else if (pending_reqs.size() > 0) begin
          in_valid      <= 1'b1;
          command       <= pending_reqs[0].cmd;
          request_size  <= pending_reqs[0].size;
          freed_address <= pending_reqs[0].addr;
          void'(pending_reqs.pop_front());
        end
      end
    end
  end

  // Prediction happens at the accepting edge.
  always @(posedge clk) begin
    alloc_rsp_t rsp;
    in_ready_seen <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      predict_alloc('{cmd: command, size: request_size, addr: freed_address}, rsp);
      owed_rsps.push_back(rsp);
      // A successful allocate can later be handed back by the stimulus.
      if (command == CMD_ALLOC && rsp.status == ST_OK) begin
        live_base.push_back(rsp.block_address);
        live_size.push_back(request_size);
      end
    end
  end

  // Receiver readiness: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ~out_ready;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin
    alloc_rsp_t exp_rsp;
    if (rst_n && out_valid && out_ready) begin
      if (owed_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: address %h status %0d", block_address, status);
      end else begin
        exp_rsp = owed_rsps.pop_front();
        if (block_address !== exp_rsp.block_address || status !== exp_rsp.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected address %h status %0d, got %h %0d",
                     exp_rsp.block_address, exp_rsp.status, block_address, status);
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        hold_off > 0 || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic add_req(input logic [1:0] c, input logic [23:0] s, input logic [31:0] a);
    pending_reqs.push_back('{cmd: c, size: s, addr: a});
  endtask

  // Waits until every queued command went in and every result came back.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || owed_rsps.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write over the configuration channel, only while idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == 2'(REG_MEM_START)) mem_start_q = val;
    else if (idx == 2'(REG_MEM_END)) mem_end_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random phase: mostly allocate/free pairs from a small live set.
  task automatic random_phase(input int unsigned n);
    int unsigned k;
    logic [23:0] sz;
    for (int unsigned i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 3) begin
        add_req(CMD_INIT, 24'($urandom), $urandom);
        live_base.delete(); live_size.delete();
      end else if (k < 5) begin
        add_req(CMD_NOP, 24'($urandom), $urandom);
      end else if (k < 50) begin
        sz = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 600));
        add_req(CMD_ALLOC, sz, $urandom);
      end else begin
        // Free either a block the prediction handed out or a random one.
        drain_live_one(sz, k);
      end
    end
  endtask

  // Enqueues one free: a recorded live block most of the time.
  task automatic drain_live_one(inout logic [23:0] sz, input int unsigned k);
    int unsigned j;
    if (live_base.size() > 0 && k < 92) begin
      j = $urandom_range(0, live_base.size() - 1);
      add_req(CMD_FREE, live_size[j], live_base[j]);
      live_base.delete(j);
      live_size.delete(j);
    end else begin
      add_req(CMD_FREE, 24'($urandom_range(0, 200)),
              ($urandom_range(0, 1) == 0) ? $urandom : (32'($urandom_range(0, 4095)) << 4));
    end
  endtask

  initial begin
    mem_start_q = 32'd0;
    mem_end_q   = 32'd65536;
    seg_cnt     = 0;
    capacity    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: allocate before init, nop, then a small memory.
    add_req(CMD_ALLOC, 24'd0, 32'd0);
    add_req(CMD_NOP, 24'hFFFFFF, 32'hFFFFFFFF);
    add_req(CMD_INIT, 24'd0, 32'd0);
    add_req(CMD_ALLOC, 24'd0, 32'd0);
    add_req(CMD_ALLOC, 24'd1, 32'd0);
    add_req(CMD_ALLOC, 24'hFFFFFF, 32'd0);
    drain();

    write_reg(2'(REG_MEM_START), 32'h0000_1003);
    write_reg(2'(REG_MEM_END), 32'h0000_1400);
    write_reg(2'd2, 32'hDEAD_BEEF);   // index beyond the registers is ignored
    add_req(CMD_INIT, 24'd0, 32'd0);
    add_req(CMD_ALLOC, 24'd16, 32'd0);   // 0x1020
    add_req(CMD_ALLOC, 24'd17, 32'd0);   // 0x1030
    add_req(CMD_ALLOC, 24'd32, 32'd0);   // 0x1050
    add_req(CMD_FREE, 24'd32, 32'h1030); // isolated, no free neighbor
    add_req(CMD_FREE, 24'd16, 32'h1020); // header is not a neighbor
    add_req(CMD_ALLOC, 24'd1000, 32'd0); // larger than any free piece
    add_req(CMD_FREE, 24'd32, 32'h1050); // merges both sides
    // Fill the table with isolated holes until it reports full.
    for (int unsigned i = 0; i < 18; i++) add_req(CMD_FREE, 24'd16, 32'h8000 + i * 64);
    drain();

    // Empty memory, and an end that rounds to the top of the address space.
    write_reg(2'(REG_MEM_END), 32'h0000_1010);
    add_req(CMD_INIT, 24'd0, 32'd0);
    add_req(CMD_ALLOC, 24'd0, 32'd0);
    drain();
    write_reg(2'(REG_MEM_START), 32'hFFFF_FF00);
    write_reg(2'(REG_MEM_END), 32'hFFFF_FFFF);
    add_req(CMD_INIT, 24'd0, 32'd0);
    add_req(CMD_ALLOC, 24'd240, 32'd0);
    add_req(CMD_FREE, 24'd240, 32'hFFFF_FF10);
    drain();

    // Random phases over several settings, extremes included.
    write_reg(2'(REG_MEM_START), 32'd0);
    write_reg(2'(REG_MEM_END), 32'h0000_2000);
    add_req(CMD_INIT, 24'd0, 32'd0);
    random_phase(250);
    // Keep the output stalled while input keeps coming so the block backs up.
    hold_off = 300;
    drain();

    write_reg(2'(REG_MEM_START), $urandom);
    write_reg(2'(REG_MEM_END), 32'hFFFF_FFFF);
    add_req(CMD_INIT, 24'd0, 32'd0);
    random_phase(230);
    drain();

    write_reg(2'(REG_MEM_START), 32'h0000_0400);
    write_reg(2'(REG_MEM_END), 32'h0000_0C00);
    add_req(CMD_INIT, 24'd0, 32'd0);
    random_phase(220);
    drain();

    if (mismatches == 0 && owed_rsps.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
